>>> hdl/tlta_pkg.sv
package tlta_pkg;

  localparam int KIND_W = 3;
  localparam int BYTES_W = 40;
  localparam int RATE_W = 40;
  localparam int WIN_W = 32;
  localparam int TIME_W = 63;
  localparam int CRED_W = 44;
  localparam int VERD_W = 2;

  localparam logic [KIND_W-1:0] KIND_CONSUME = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CFG_CLASS = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CFG_WORK = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DROP = 3'd4;

  localparam logic [VERD_W-1:0] VERD_OK = 2'd0;
  localparam logic [VERD_W-1:0] VERD_CLASS = 2'd1;
  localparam logic [VERD_W-1:0] VERD_WORK = 2'd2;

  localparam int DEF_NUM_CLASSES = 8;
  localparam int DEF_NUM_WORKLOADS = 64;
  localparam int DEF_NS_PER_SEC = 1000000000;
  localparam int FLOOR_DIV = 100;

  localparam logic [CRED_W-1:0] CRED_MAX = {CRED_W{1'b1}};
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic [CRED_W-1:0] cap;
    logic [CRED_W-1:0] tok;
    logic [TIME_W-1:0] last;
  } bucket_t;

endpackage

>>> hdl/tlta_muldiv.sv
module tlta_muldiv (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  input  logic [63:0] d,
  output logic        done,
  output logic [63:0] q
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL = 2'd1;
  localparam logic [1:0] ST_DIV = 2'd2;

  logic [1:0]   state;
  logic [6:0]   cnt;
  logic [63:0]  mcand;
  logic [63:0]  mplier;
  logic [127:0] prod;
  logic [63:0]  dvs;
  logic [64:0]  rem;
  logic [64:0]  rem_sh;
  logic [64:0]  sum_hi;

  assign sum_hi = {1'b0, prod[127:64]} + (mplier[0] ? {1'b0, mcand} : 65'd0);
  assign rem_sh = {rem[63:0], prod[127]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_MUL;
            cnt <= 7'd0;
            mcand <= a;
            mplier <= b;
            dvs <= d;
            prod <= '0;
          end
        end
        ST_MUL: begin
          prod <= {sum_hi, prod[63:1]};
          mplier <= mplier >> 1;
          cnt <= cnt + 7'd1;
          if (cnt == 7'd63) begin
            state <= ST_DIV;
            cnt <= 7'd0;
            rem <= '0;
          end
        end
        ST_DIV: begin
          if (cnt == 7'd0 && (dvs == 64'd0 || prod[127:64] >= dvs)) begin
            q <= '1;
            done <= 1'b1;
            state <= ST_IDLE;
          end else begin
            if (cnt == 7'd0) begin
              rem <= {1'b0, prod[127:64]};
              prod <= {prod[63:0], 64'd0};
              cnt <= 7'd1;
            end else begin
              if (rem_sh >= {1'b0, dvs}) begin
                rem <= rem_sh - {1'b0, dvs};
                q <= {q[62:0], 1'b1};
              end else begin
                rem <= rem_sh;
                q <= {q[62:0], 1'b0};
              end
              prod <= {prod[126:0], 1'b0};
              cnt <= cnt + 7'd1;
              if (cnt == 7'd64) begin
                done <= 1'b1;
                state <= ST_IDLE;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held");
  assert property (@(posedge clk) disable iff (rst)
      (state == ST_IDLE && !start) |=> !done)
    else $error("done without start");
  assert property (@(posedge clk) disable iff (rst)
      (state == ST_MUL) |=> (state == ST_MUL || state == ST_DIV))
    else $error("bad exit from multiply");
endmodule

>>> hdl/two_level_token_bucket_admission.sv
// Each refill, retry or capacity product runs the shift-and-add multiplier and then the
// restoring divider (64 steps each); a request needs at most three products.
// Throughput: one request at a time; the next input transfer is taken only once the result
// transfer has completed.
// Reset (rst, synchronous, active high) clears all valid bits and the control state.
module two_level_token_bucket_admission #(
  parameter int NUM_CLASSES = tlta_pkg::DEF_NUM_CLASSES,
  parameter int NUM_WORKLOADS = tlta_pkg::DEF_NUM_WORKLOADS,
  parameter int NS_PER_SEC = tlta_pkg::DEF_NS_PER_SEC
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  // tdata: byte_count, rate, burst_window, now_ns, zero pad (176 bits)
  input  logic [175:0]  s_tdata,
  // tuser: kind, class_id, workload_id
  input  logic [11:0]   s_tuser,
  output logic          m_tvalid,
  input  logic          m_tready,
  // tdata: admitted, verdict, retry_at, class_credit, workload_credit, zero pad (160 bits)
  output logic [159:0]  m_tdata
);
  import tlta_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_PREP = 4'd1;
  localparam logic [3:0] ST_CREF = 4'd2;
  localparam logic [3:0] ST_WREF = 4'd3;
  localparam logic [3:0] ST_DEC = 4'd4;
  localparam logic [3:0] ST_RETRY = 4'd5;
  localparam logic [3:0] ST_CFG = 4'd6;
  localparam logic [3:0] ST_WB = 4'd7;
  localparam logic [3:0] ST_OUT = 4'd8;
  localparam logic [3:0] ST_WAIT = 4'd9;
  localparam logic [3:0] ST_FLR = 4'd10;
  localparam logic [3:0] ST_CFGW = 4'd11;
  localparam logic [63:0] NSPS = 64'(NS_PER_SEC);

  logic [3:0]  state;
  logic [3:0]  ret_state;
  logic [KIND_W-1:0] kind;
  logic [2:0]  cid;
  logic [5:0]  wid;
  logic [BYTES_W-1:0] bytes;
  logic [RATE_W-1:0]  rate_in;
  logic [WIN_W-1:0]   win;
  logic [TIME_W-1:0]  now;

  logic [NUM_CLASSES-1:0]   cvalid;
  logic [NUM_WORKLOADS-1:0] wvalid;
  bucket_t cmem [NUM_CLASSES];
  bucket_t wmem [NUM_WORKLOADS];
  bucket_t cb;
  bucket_t wb;
  logic cin;
  logic win_ok;
  logic cv;
  logic wv;

  logic        md_start;
  logic        md_done;
  logic [63:0] md_a;
  logic [63:0] md_b;
  logic [63:0] md_d;
  logic [63:0] md_q;
  logic        md_busy;

  logic        admitted;
  logic [VERD_W-1:0] verdict;
  logic [TIME_W-1:0] retry;
  logic [TIME_W-1:0] wait_q;

  tlta_muldiv u_md (
    .clk(clk), .rst(rst), .start(md_start), .a(md_a), .b(md_b), .d(md_d),
    .done(md_done), .q(md_q)
  );

  assign s_tready = (state == ST_IDLE) && !m_tvalid;

  assign cin = 32'(cid) < NUM_CLASSES;
  assign win_ok = 32'(wid) < NUM_WORKLOADS;
  assign cv = cin && cvalid[cid];
  assign wv = win_ok && wvalid[wid];

  function automatic logic [CRED_W-1:0] add_sat(input bucket_t b, input logic [63:0] amt);
    logic [63:0] room;
    room = 64'(b.cap) - 64'(b.tok);
    if (b.tok >= b.cap || amt >= room) return b.cap;
    return b.tok + amt[CRED_W-1:0];
  endfunction

  function automatic logic [63:0] elapsed(input bucket_t b, input logic [TIME_W-1:0] t,
                                          input logic [63:0] lim);
    logic [63:0] el;
    el = 64'(t) - 64'(b.last);
    return (el > lim) ? lim : el;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cvalid <= '0;
      wvalid <= '0;
      m_tvalid <= 1'b0;
      md_start <= 1'b0;
      md_busy <= 1'b0;
    end else begin
      md_start <= 1'b0;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid && s_tready) begin
            bytes <= s_tdata[39:0];
            rate_in <= s_tdata[79:40];
            win <= s_tdata[111:80];
            now <= s_tdata[174:112];
            kind <= s_tuser[2:0];
            cid <= s_tuser[5:3];
            wid <= s_tuser[11:6];
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          cb <= cin ? cmem[cid] : '0;
          wb <= win_ok ? wmem[wid] : '0;
          admitted <= 1'b0;
          verdict <= VERD_OK;
          retry <= '0;
          case (kind)
            KIND_CONSUME: begin
              if (!cv) begin
                verdict <= VERD_CLASS;
                state <= ST_OUT;
              end else if (!wv) begin
                verdict <= VERD_WORK;
                state <= ST_OUT;
              end else state <= ST_CREF;
            end
            KIND_RELEASE: state <= ST_CREF;
            KIND_CFG_CLASS, KIND_CFG_WORK: state <= ST_CFG;
            KIND_DROP: begin
              if (win_ok) begin
                wvalid[wid] <= 1'b0;
                state <= ST_WB;
              end else state <= ST_OUT;
            end
            default: state <= ST_OUT;
          endcase
        end
        ST_CREF, ST_WREF: begin
          if (state == ST_CREF && !(cv && now > cb.last && cb.rate != '0)) begin
            if (cv && now > cb.last) cb.last <= now;
            if (kind == KIND_RELEASE && cv) cb.tok <= add_sat(cb, 64'(bytes));
            state <= ST_WREF;
          end else if (state == ST_WREF && !(wv && now > wb.last && wb.rate != '0)) begin
            if (wv && now > wb.last) wb.last <= now;
            if (kind == KIND_RELEASE && wv) wb.tok <= add_sat(wb, 64'(bytes));
            state <= (kind == KIND_RELEASE) ? ST_WB : ST_DEC;
          end else if (!md_busy) begin
            md_busy <= 1'b1;
            md_start <= 1'b1;
            md_d <= NSPS;
            if (state == ST_CREF) begin
              md_a <= 64'(cb.rate);
              md_b <= elapsed(cb, now, NSPS);
            end else begin
              md_a <= 64'(wb.rate);
              md_b <= elapsed(wb, now, NSPS);
            end
          end else if (md_done) begin
            md_busy <= 1'b0;
            if (state == ST_CREF) begin
              cb.last <= now;
              cb.tok <= add_sat(cb, md_q);
              md_a <= md_q;
            end else begin
              wb.last <= now;
              wb.tok <= add_sat(wb, md_q);
            end
            state <= ST_WAIT;
            ret_state <= state;
          end
        end
        ST_WAIT: begin
          if (kind == KIND_RELEASE && ret_state == ST_CREF) begin
            cb.tok <= add_sat(cb, 64'(bytes));
            state <= ST_WREF;
          end else if (kind == KIND_RELEASE) begin
            wb.tok <= add_sat(wb, 64'(bytes));
            state <= ST_WB;
          end else state <= (ret_state == ST_CREF) ? ST_WREF : ST_DEC;
        end
        ST_DEC: begin
          if (64'(cb.tok) < 64'(bytes)) begin
            verdict <= VERD_CLASS;
            state <= ST_RETRY;
          end else if (64'(wb.tok) < 64'(bytes)) begin
            verdict <= VERD_WORK;
            state <= ST_RETRY;
          end else begin
            cb.tok <= cb.tok - CRED_W'(bytes);
            wb.tok <= wb.tok - CRED_W'(bytes);
            admitted <= 1'b1;
            state <= ST_WB;
          end
        end
        ST_RETRY: begin
          if ((verdict == VERD_CLASS ? cb.rate : wb.rate) == '0) begin
            retry <= now;
            state <= ST_WB;
          end else if (!md_busy) begin
            md_busy <= 1'b1;
            md_start <= 1'b1;
            md_a <= 64'(bytes) - 64'(verdict == VERD_CLASS ? cb.tok : wb.tok);
            md_b <= NSPS;
            md_d <= 64'(verdict == VERD_CLASS ? cb.rate : wb.rate);
          end else if (md_done) begin
            md_busy <= 1'b0;
            if (md_q >= 64'(TIME_MAX) - 64'(now)) retry <= TIME_MAX;
            else retry <= now + md_q[TIME_W-1:0] + TIME_W'(1);
            state <= ST_WB;
          end
        end
        ST_CFG: begin
          if (rate_in == '0 || win == '0) begin
            wait_q <= '0;
            state <= ST_CFGW;
          end else if (!md_busy) begin
            md_busy <= 1'b1;
            md_start <= 1'b1;
            md_a <= 64'(rate_in);
            md_b <= 64'(win);
            md_d <= NSPS;
          end else if (md_done) begin
            md_busy <= 1'b0;
            wait_q <= md_q[TIME_W-1:0];
            state <= ST_FLR;
          end
        end
        ST_FLR: begin
          if (!md_busy) begin
            md_busy <= 1'b1;
            md_start <= 1'b1;
            md_a <= 64'(rate_in);
            md_b <= 64'd1;
            md_d <= 64'(FLOOR_DIV);
          end else if (md_done) begin
            md_busy <= 1'b0;
            if (64'(wait_q) < md_q) wait_q <= md_q[TIME_W-1:0];
            state <= ST_CFGW;
          end
        end
        ST_CFGW: begin
          if (kind == KIND_CFG_CLASS) begin
            if (32'(cid) < NUM_CLASSES) begin
              cvalid[cid] <= 1'b1;
              cmem[cid] <= '{rate: rate_in,
                cap: (64'(wait_q) > 64'(CRED_MAX)) ? CRED_MAX : wait_q[CRED_W-1:0],
                tok: (64'(wait_q) > 64'(CRED_MAX)) ? CRED_MAX : wait_q[CRED_W-1:0],
                last: now};
            end
          end else if (32'(wid) < NUM_WORKLOADS) begin
            wvalid[wid] <= 1'b1;
            wmem[wid] <= '{rate: rate_in,
              cap: (64'(wait_q) > 64'(CRED_MAX)) ? CRED_MAX : wait_q[CRED_W-1:0],
              tok: (64'(wait_q) > 64'(CRED_MAX)) ? CRED_MAX : wait_q[CRED_W-1:0],
              last: now};
          end
          state <= ST_OUT;
        end
        ST_WB: begin
          if (32'(cid) < NUM_CLASSES && cvalid[cid]) cmem[cid] <= cb;
          if (32'(wid) < NUM_WORKLOADS) wmem[wid] <= wb;
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!m_tvalid) begin
            m_tvalid <= 1'b1;
            m_tdata <= {6'd0,
              ((32'(wid) < NUM_WORKLOADS) && wvalid[wid]) ? wmem[wid].tok : CRED_W'(0),
              ((32'(cid) < NUM_CLASSES) && cvalid[cid]) ? cmem[cid].tok : CRED_W'(0),
              retry, verdict, admitted};
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) s_tready |-> state == ST_IDLE)
    else $error("ready outside idle");
  assert property (@(posedge clk) disable iff (rst)
      m_tvalid && m_tdata[0] |-> m_tdata[2:1] == VERD_OK)
    else $error("admitted with ceiling verdict");
  assert property (@(posedge clk) disable iff (rst)
      (s_tvalid && s_tready) |=> !s_tready)
    else $error("second item taken");
endmodule
